[src/bbp_pkg.sv]
package bbp_pkg;

  // Default history table depth
  localparam int unsigned TABLE_ENTRIES = 1024;

  // The table index starts at this program counter bit
  localparam int unsigned PC_IDX_LSB = 2;

  localparam int unsigned PC_W    = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned ENTRY_W = 2;
  localparam int unsigned MODE_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_STATIC  = 2'd0,
    MODE_ONE_BIT = 2'd1,
    MODE_TWO_BIT = 2'd2
  } mode_e;

  typedef struct packed {
    logic [PC_W-1:0] branch_pc;
    logic            branch_taken;
  } bbp_req_t;

  typedef struct packed {
    logic               pred_taken;
    logic               prediction_correct;
    logic [COUNT_W-1:0] total_branches;
    logic [COUNT_W-1:0] correct_branches;
  } bbp_rsp_t;

endpackage

[src/bimodal_branch_predictor.sv]
// Bimodal branch predictor, one history table in a synchronous RAM.
// Path: a request passes the table read register, then the output register; at other than
//   power-of-two depth a reciprocal index reduction (quotient, then remainder) comes first.
// Throughput: 1 request per cycle at power-of-two depth while the output does not stall
//   (read-modify-write with write forwarding), else a new request waits for the index unit.
// Reset: mode and counts clear at once; a sweep then zeroes the table, stalling requests.
module bimodal_branch_predictor import bbp_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bbp_req_t          in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bbp_rsp_t          out_rsp_o
);

  localparam int unsigned IdxW    = $clog2(TableEntries);
  localparam bit          IsPow2  = (TableEntries == (1 << IdxW));
  localparam int unsigned ValW    = PC_W - PC_IDX_LSB;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STATIC;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing sweep after reset
  // ---------------------------------------------------------------------------
  logic            clr_active_q;
  logic [IdxW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == IdxW'(TableEntries - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic s1_adv;     // stage 1 hands its result to the output register
  logic s1_load;    // stage 1 can take a new table read this cycle
  logic out_valid_q;

  assign s1_adv  = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_load = !s1_valid_q || s1_adv;

  // Read issue: index, outcome and a strobe that starts the table read
  logic            rd_fire;
  logic [IdxW-1:0] rd_idx;
  logic            rd_taken;
  logic            in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  if (IsPow2) begin : g_mask_idx
    // Index is a plain bit field of the program counter
    assign in_stall_o = clr_active_q || !s1_load;
    assign rd_fire    = in_accept;
    assign rd_idx     = in_req_i.branch_pc[PC_IDX_LSB +: IdxW];
    assign rd_taken   = in_req_i.branch_taken;
  end else begin : g_recip_idx
    // Reduce modulo the table depth: a reciprocal multiply yields the quotient,
    // and a multiply and subtract yields the remainder in the next cycle.
    localparam int unsigned     ShiftS = ValW + IdxW;
    localparam int unsigned     QuoW   = ValW - IdxW + 1;
    localparam int unsigned     ProdW  = ValW + 32;
    localparam longint unsigned RecipL = ((64'd1 << ShiftS) + 64'(TableEntries) - 64'd1)
                                         / 64'(TableEntries);
    localparam logic [31:0]     RecipM = 32'(RecipL);

    logic             div_busy_q;
    logic             div_step_q;
    logic             div_done_q;
    logic [ValW-1:0]  div_val_q;
    logic [QuoW-1:0]  div_quo_q;
    logic [IdxW-1:0]  div_rem_q;
    logic             div_taken_q;
    logic [ProdW-1:0] div_prod;
    logic [ValW-1:0]  div_back;
    logic [ValW-1:0]  div_diff;

    assign div_prod = ProdW'(div_val_q) * ProdW'(RecipM);
    assign div_back = ValW'(div_quo_q) * ValW'(TableEntries);
    assign div_diff = div_val_q - div_back;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_busy_q <= 1'b0;
        div_step_q <= 1'b0;
        div_done_q <= 1'b0;
      end else if (in_accept) begin
        div_busy_q <= 1'b1;
        div_step_q <= 1'b0;
      end else if (div_busy_q) begin
        div_step_q <= 1'b1;
        if (div_step_q) begin
          div_busy_q <= 1'b0;
          div_done_q <= 1'b1;
        end
      end else if (div_done_q && s1_load) begin
        div_done_q <= 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (in_accept) begin
        div_val_q   <= in_req_i.branch_pc[PC_W-1:PC_IDX_LSB];
        div_taken_q <= in_req_i.branch_taken;
      end
      if (div_busy_q && !div_step_q) begin
        div_quo_q <= div_prod[ShiftS +: QuoW];
      end
      if (div_busy_q && div_step_q) begin
        div_rem_q <= div_diff[IdxW-1:0];
      end
    end

    assign in_stall_o = clr_active_q || div_busy_q || div_done_q;
    assign rd_fire    = div_done_q && s1_load;
    assign rd_idx     = div_rem_q;
    assign rd_taken   = div_taken_q;
  end

  // ---------------------------------------------------------------------------
  // History table: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] hist_mem [TableEntries];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_fire) begin
      rd_data_q <= hist_mem[rd_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: predict, update entry, count
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0]    s1_idx_q;
  logic               s1_taken_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= rd_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      s1_idx_q   <= rd_idx;
      s1_taken_q <= rd_taken;
    end
  end

  // Forward the last written entry: a write lands on the same edge that a
  // following read samples, so the RAM returns the old value on a match.
  logic               fwd_valid_q;
  logic [IdxW-1:0]    fwd_idx_q;
  logic [ENTRY_W-1:0] fwd_data_q;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] entry_d;
  logic               pred;
  logic               correct;
  logic               upd_we;

  assign entry = (fwd_valid_q && fwd_idx_q == s1_idx_q) ? fwd_data_q : rd_data_q;

  always_comb begin
    pred    = 1'b0;
    entry_d = entry;
    upd_we  = 1'b0;
    unique case (mode_q)
      MODE_STATIC: begin
        pred = 1'b0;
      end
      MODE_ONE_BIT: begin
        pred    = (entry == ENTRY_W'(1));
        entry_d = {1'b0, s1_taken_q};
        upd_we  = 1'b1;
      end
      default: begin
        // two-bit counter; the unused fourth mode code behaves the same
        pred   = entry[ENTRY_W-1];
        upd_we = 1'b1;
        if (s1_taken_q && entry != '1) begin
          entry_d = entry + 1'b1;
        end else if (!s1_taken_q && entry != '0) begin
          entry_d = entry - 1'b1;
        end
      end
    endcase
  end

  assign correct = (pred == s1_taken_q);

  // Memory write port: sweep while clearing, else the stage 1 update
  assign mem_we    = clr_active_q || (s1_adv && upd_we);
  assign mem_waddr = clr_active_q ? clr_addr_q : s1_idx_q;
  assign mem_wdata = clr_active_q ? '0 : entry_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_adv && upd_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && upd_we) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= entry_d;
    end
  end

  // Saturating branch and hit counts
  logic [COUNT_W-1:0] total_q;
  logic [COUNT_W-1:0] hits_q;
  logic [COUNT_W-1:0] total_d;
  logic [COUNT_W-1:0] hits_d;

  assign total_d = (&total_q) ? total_q : total_q + 1'b1;
  assign hits_d  = (correct && !(&hits_q)) ? hits_q + 1'b1 : hits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      hits_q  <= '0;
    end else if (s1_adv) begin
      total_q <= total_d;
      hits_q  <= hits_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, drop once taken
  // ---------------------------------------------------------------------------
  bbp_rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.pred_taken         <= pred;
      out_q.prediction_correct <= correct;
      out_q.total_branches     <= total_d;
      out_q.correct_branches   <= hits_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

[src/bbp_checker.sv]
module bbp_checker import bbp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic [MODE_W-1:0] cfg_wdata_i,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input bbp_req_t          in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input bbp_rsp_t          out_rsp_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // Block requests while the table sweep runs after reset
  a_clear_stall: assert property (@(posedge clk_i)
    !rst_ni |=> in_stall_o)
    else $error("request accepted during table clear");

  // Never count more hits than branches
  a_hits_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.correct_branches <= out_rsp_o.total_branches)
    else $error("hit count exceeds branch count");

  // Advance the branch count by one per back-to-back result
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o
      || out_rsp_o.total_branches == $past(out_rsp_o.total_branches) + 1'b1
      || &$past(out_rsp_o.total_branches))
    else $error("branch count skipped");

  // A correct flag implies a hit was counted
  a_correct_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.prediction_correct |-> out_rsp_o.correct_branches != '0)
    else $error("correct result without hit count");

endmodule

bind bimodal_branch_predictor bbp_checker u_bbp_checker (.*);

[tb/bimodal_branch_predictor_checker.sv]
module bimodal_branch_predictor_checker import bbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  bbp_req_t          in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  bbp_rsp_t          out_rsp_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic [ENTRY_W-1:0] counter_tbl [TABLE_ENTRIES];
  logic [MODE_W-1:0]  mode_q;
  logic [COUNT_W-1:0] branch_cnt_q;
  logic [COUNT_W-1:0] hit_cnt_q;
  bbp_rsp_t           expected_rsp_q [$];
  bbp_rsp_t           oldest_rsp;

  function automatic logic [COUNT_W-1:0] sat_incr(logic [COUNT_W-1:0] cnt);
    return (cnt == '1) ? cnt : cnt + 1'b1;
  endfunction

  // Predict from the entry as it stands, then train it.
  function automatic bbp_rsp_t predict_and_train(bbp_req_t req);
    int unsigned        idx;
    logic [ENTRY_W-1:0] entry;
    bbp_rsp_t           rsp;
    idx   = (req.branch_pc >> PC_IDX_LSB) % TABLE_ENTRIES;
    entry = counter_tbl[idx];
    if (mode_q == MODE_STATIC) begin
      rsp.pred_taken = 1'b0;
    end else if (mode_q == MODE_ONE_BIT) begin
      rsp.pred_taken = (entry == 2'd1);
    end else begin
      rsp.pred_taken = (entry >= 2'd2);
    end
    rsp.prediction_correct = (rsp.pred_taken == req.branch_taken);
    branch_cnt_q = sat_incr(branch_cnt_q);
    if (rsp.prediction_correct) hit_cnt_q = sat_incr(hit_cnt_q);
    if (mode_q == MODE_ONE_BIT) begin
      counter_tbl[idx] = req.branch_taken ? 2'd1 : 2'd0;
    end else if (mode_q != MODE_STATIC) begin
      if (req.branch_taken && entry != 2'd3) counter_tbl[idx] = entry + 1'b1;
      else if (!req.branch_taken && entry != 2'd0) counter_tbl[idx] = entry - 1'b1;
    end
    rsp.total_branches   = branch_cnt_q;
    rsp.correct_branches = hit_cnt_q;
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (counter_tbl[i]) counter_tbl[i] = '0;
      mode_q       = MODE_STATIC;
      branch_cnt_q = '0;
      hit_cnt_q    = '0;
      expected_rsp_q.delete();
      pending_o    = 0;
    end else begin
      // A result never leaves in the cycle its request is accepted, so check first.
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o++;
        end else begin
          oldest_rsp = expected_rsp_q.pop_front();
          if (out_rsp_i.pred_taken !== oldest_rsp.pred_taken) begin
            $error("pred_taken: expected %0d, actual %0d",
                   oldest_rsp.pred_taken, out_rsp_i.pred_taken);
            fail_count_o++;
          end
          if (out_rsp_i.prediction_correct !== oldest_rsp.prediction_correct) begin
            $error("prediction_correct: expected %0d, actual %0d",
                   oldest_rsp.prediction_correct, out_rsp_i.prediction_correct);
            fail_count_o++;
          end
          if (out_rsp_i.total_branches !== oldest_rsp.total_branches) begin
            $error("total_branches: expected %0d, actual %0d",
                   oldest_rsp.total_branches, out_rsp_i.total_branches);
            fail_count_o++;
          end
          if (out_rsp_i.correct_branches !== oldest_rsp.correct_branches) begin
            $error("correct_branches: expected %0d, actual %0d",
                   oldest_rsp.correct_branches, out_rsp_i.correct_branches);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        expected_rsp_q.push_back(predict_and_train(in_req_i));
      end
      if (cfg_we_i) mode_q = cfg_wdata_i;
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

[tb/bimodal_branch_predictor_tb.sv]
module bimodal_branch_predictor_tb;
  import bbp_pkg::*;

  // Mode value three decodes like the two-bit counter.
  localparam logic [MODE_W-1:0] MODE_TWO_BIT_ALT = 2'd3;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned PHASE_ITEMS   = 300;
  localparam int unsigned NUM_PHASES    = 7;
  localparam int unsigned HOT_ENTRIES   = 16;
  // Long receiver hold-off: start it at this result, stall for LONG_HOLD.
  localparam int unsigned LONG_HOLD_AT  = 700;
  localparam int unsigned LONG_HOLD     = 200;
  // Covers the table sweep after reset and the long hold-off with margin.
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES  = 16;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [MODE_W-1:0] cfg_wdata = MODE_STATIC;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  bbp_req_t          in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  bbp_rsp_t          out_rsp;

  int                fail_count;
  int                pending;
  // Burst phases: neither side idles.
  bit                burst     = 1'b0;
  int unsigned       rx_count  = 0;
  int unsigned       idle_cycles = 0;
  logic [IDX_W-1:0]  hot_idx [HOT_ENTRIES];
  logic [MODE_W-1:0] phase_mode [NUM_PHASES] = '{MODE_TWO_BIT, MODE_ONE_BIT,
                                                 MODE_TWO_BIT_ALT, MODE_STATIC,
                                                 MODE_TWO_BIT, MODE_ONE_BIT,
                                                 MODE_TWO_BIT};

  bimodal_branch_predictor i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  bimodal_branch_predictor_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall for a random wait before each result, drop the
  // stall and wait for the result. Once, hold off for a long stretch so that
  // the pipeline fills up and backs up into the request side.
  initial begin
    int unsigned wait_cycles;
    @(negedge clk);
    forever begin
      wait_cycles = burst ? 0 : $urandom_range(0, 9);
      if (rx_count == LONG_HOLD_AT) wait_cycles = LONG_HOLD;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      rx_count++;
      @(negedge clk);
    end
  end

  function automatic bbp_req_t branch_req(logic [PC_W-1:0] pc, logic taken);
    bbp_req_t req;
    req.branch_pc    = pc;
    req.branch_taken = taken;
    return req;
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  // Entered and left just after a falling edge; valid stays high across
  // back-to-back requests.
  task automatic send_branch(input bbp_req_t req);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  // Change mode only with the block drained: wait until every result is back.
  task automatic write_mode(input logic [MODE_W-1:0] mode);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random branch: mostly a small set of hot table entries with a bias per
  // entry so that counters train and saturate, else a fully random pc.
  task automatic send_random_branch();
    int unsigned     slot;
    int unsigned     bias;
    logic [PC_W-1:0] pc;
    pc = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      slot = $urandom_range(0, HOT_ENTRIES - 1);
      pc[PC_IDX_LSB +: IDX_W] = hot_idx[slot];
      case (slot % 4)
        0:       bias = 95;
        1:       bias = 5;
        2:       bias = 50;
        default: bias = 80;
      endcase
      send_branch(branch_req(pc, $urandom_range(0, 99) < bias));
    end else begin
      send_branch(branch_req(pc, 1'($urandom_range(0, 1))));
    end
  endtask

  initial begin
    foreach (hot_idx[i]) hot_idx[i] = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Static mode straight out of reset, pc extremes.
    send_branch(branch_req(32'h0000_0000, 1'b0));
    send_branch(branch_req(32'hFFFF_FFFF, 1'b1));
    send_branch(branch_req(32'h0000_0004, 1'b1));

    // One-bit mode: learn, hit, then alias through the same entry with
    // differing upper and low pc bits.
    write_mode(MODE_ONE_BIT);
    send_branch(branch_req(32'h0000_0100, 1'b1));
    send_branch(branch_req(32'h0000_0100, 1'b1));
    send_branch(branch_req(32'h0000_1101, 1'b0));
    send_branch(branch_req(32'h0000_0103, 1'b0));

    // Two-bit mode: saturate up, saturate down, leave another entry at three.
    write_mode(MODE_TWO_BIT);
    repeat (4) send_branch(branch_req(32'h0000_0200, 1'b1));
    repeat (4) send_branch(branch_req(32'h0000_0200, 1'b0));
    repeat (3) send_branch(branch_req(32'hFFFF_F300, 1'b1));

    // Switch with the table kept: one-bit mode reads three as not-taken,
    // then leaves a one behind for the two-bit decode.
    write_mode(MODE_ONE_BIT);
    send_branch(branch_req(32'h0000_0300, 1'b0));
    send_branch(branch_req(32'h0000_0500, 1'b1));

    // Mode three acts as two-bit and reads a one as not-taken.
    write_mode(MODE_TWO_BIT_ALT);
    repeat (2) send_branch(branch_req(32'h0000_0500, 1'b1));

    // Static leaves the entry alone; two-bit mode still finds it at three.
    write_mode(MODE_STATIC);
    send_branch(branch_req(32'h0000_0500, 1'b1));
    write_mode(MODE_TWO_BIT);
    send_branch(branch_req(32'h0000_0500, 1'b0));

    // Random phases, one mode each; some phases run without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mode(phase_mode[p]);
      burst = (p == 1 || p == 4);
      repeat (PHASE_ITEMS) send_random_branch();
      burst = 1'b0;
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
